FILE: src/skgs_pkg.sv
// Shared types and constants of the signature kernel grid solver.
package skgs_pkg;

  // Field widths of the item and result channels, the accumulator and the rounded quotient.
  localparam int unsigned DinW  = 32;
  localparam int unsigned KvalW = 64;
  localparam int unsigned AccW  = 128;
  localparam int unsigned QW    = 96;

  // Configuration port widths.
  localparam int unsigned RowsW     = 16;
  localparam int unsigned ColsW     = 11;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 1;

  // Default line depth.
  localparam int unsigned MaxColsDefault = 1024;

  // Register indexes of the configuration port.
  localparam logic [CfgIndexW-1:0] CfgGridRows = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgGridCols = 1'b1;

  // Fixed-point constants in Q32.32.
  localparam logic [KvalW-1:0] OneQ32  = 64'h0000_0001_0000_0000;
  localparam logic [KvalW-1:0] KvalMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [KvalW-1:0] KvalMin = 64'h8000_0000_0000_0000;

  // Rounding constants for the final shift by 32 (half, and half plus one).
  localparam logic [AccW-1:0] RoundHalf    = 128'h8000_0000;
  localparam logic [AccW-1:0] RoundHalfInc = 128'h8000_0001;

  // Bias added to the square before division by twelve (round to nearest).
  localparam logic [KvalW-1:0] DivBias = 64'd6;

  // Sequencer step counts.
  localparam int unsigned StepW       = 4;
  localparam logic [StepW-1:0] DivLast = 4'd8;   // load, then eight byte steps
  localparam logic [StepW-1:0] MacIssues = 4'd12; // three products of four parts

  // Command group from the controller to the datapath.
  typedef struct packed {
    logic             load;       // take the input item, read the line
    logic             square;     // multiplier forms d*d
    logic             div_load;   // load the divider with the quarter of d*d + 6
    logic             div_step;   // one byte of the divide by twelve
    logic             coef;       // form coefficients and operand magnitudes
    logic             mac_issue;  // issue one partial product
    logic [StepW-1:0] mac_step;   // which partial product
    logic             round;      // rounding add on the accumulator
    logic             finish;     // saturate, write back, load the result
    logic             row_first;  // current cell lies in the first row
    logic             end_row;    // current cell closes its row
    logic             grid_last;  // current cell closes the grid
  } skgs_cmd_t;

endpackage

FILE: src/skgs_ctrl.sv
// Sequencer, grid counters and configuration registers of the solver.
module skgs_ctrl #(
  parameter int unsigned MAX_COLS = skgs_pkg::MaxColsDefault,
  parameter int unsigned AddrW    = $clog2(MAX_COLS + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [skgs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [skgs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input handshake
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  // Datapath link
  input  logic                           out_stall_i,
  output skgs_pkg::skgs_cmd_t            cmd_o,
  output logic [AddrW-1:0]               line_addr_o
);

  localparam int unsigned ColW = $clog2(MAX_COLS);
  localparam int unsigned ExtW = (AddrW > skgs_pkg::ColsW) ? AddrW : skgs_pkg::ColsW;
  localparam logic [ExtW-1:0] MaxColsExt = ExtW'(MAX_COLS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SQUARE = 7'b0000010,
    S_DIVIDE = 7'b0000100,
    S_COEF   = 7'b0001000,
    S_MAC    = 7'b0010000,
    S_ROUND  = 7'b0100000,
    S_FINISH = 7'b1000000
  } skgs_state_e;

  skgs_state_e                     state_q, state_d;
  logic [skgs_pkg::StepW-1:0]      step_q, step_d;
  logic [ColW-1:0]                 col_q, col_d;
  logic [skgs_pkg::RowsW-1:0]      row_q, row_d;
  logic [skgs_pkg::RowsW-1:0]      grid_rows_q;
  logic [skgs_pkg::ColsW-1:0]      grid_cols_q;

  logic [skgs_pkg::RowsW-1:0]      rows_eff;
  logic [ExtW-1:0]                 cols_ext, cols_eff, col_next;
  logic [skgs_pkg::RowsW:0]        row_next;
  logic                            end_row, end_grid, fire;

  // Configuration registers; a write goes to the register its index names.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= skgs_pkg::RowsW'(1);
      grid_cols_q <= skgs_pkg::ColsW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        skgs_pkg::CfgGridRows: grid_rows_q <= cfg_wdata_i[skgs_pkg::RowsW-1:0];
        skgs_pkg::CfgGridCols: grid_cols_q <= cfg_wdata_i[skgs_pkg::ColsW-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid size: zero counts as one, columns are capped at the line depth.
  always_comb begin
    rows_eff = (grid_rows_q == '0) ? skgs_pkg::RowsW'(1) : grid_rows_q;
    cols_ext = ExtW'(grid_cols_q);
    if (cols_ext == '0) begin
      cols_eff = ExtW'(1);
    end else if (cols_ext > MaxColsExt) begin
      cols_eff = MaxColsExt;
    end else begin
      cols_eff = cols_ext;
    end
  end

  // Position of the current cell within the grid.
  assign col_next = ExtW'(col_q) + ExtW'(1);
  assign row_next = {1'b0, row_q} + (skgs_pkg::RowsW + 1)'(1);
  assign end_row  = (col_next >= cols_eff);
  assign end_grid = end_row && (row_next >= {1'b0, rows_eff});

  assign line_addr_o = col_next[AddrW-1:0];
  assign in_ready_o  = (state_q == S_IDLE);
  assign fire        = (state_q == S_FINISH) && !out_stall_i;

  // Sequencer: one item at a time through square, divide, multiply-accumulate
  // and the final rounding.
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.row_first = (row_q == '0);
    cmd_o.end_row   = end_row;
    cmd_o.grid_last = end_grid;
    cmd_o.mac_step  = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        step_d       = '0;
        state_d      = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_load = (step_q == '0);
        cmd_o.div_step = (step_q != '0);
        if (step_q == skgs_pkg::DivLast) begin
          state_d = S_COEF;
        end else begin
          step_d = step_q + skgs_pkg::StepW'(1);
        end
      end
      S_COEF: begin
        cmd_o.coef = 1'b1;
        step_d     = '0;
        state_d    = S_MAC;
      end
      S_MAC: begin
        // The last step only drains the product register into the accumulator.
        cmd_o.mac_issue = (step_q < skgs_pkg::MacIssues);
        if (step_q == skgs_pkg::MacIssues) begin
          state_d = S_ROUND;
        end else begin
          step_d = step_q + skgs_pkg::StepW'(1);
        end
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = S_FINISH;
      end
      S_FINISH: begin
        if (fire) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Grid counters advance when a result is handed over.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (end_row) begin
        col_d = '0;
        row_d = end_grid ? '0 : row_next[skgs_pkg::RowsW-1:0];
      end else begin
        col_d = col_next[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

endmodule

FILE: src/skgs_datapath.sv
// Arithmetic datapath, previous-row line memory and result register of the solver.
module skgs_datapath #(
  parameter int unsigned MAX_COLS = skgs_pkg::MaxColsDefault,
  parameter int unsigned AddrW    = $clog2(MAX_COLS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  skgs_pkg::skgs_cmd_t         cmd_i,
  input  logic [AddrW-1:0]            line_addr_i,
  input  logic [skgs_pkg::DinW-1:0]   in_data_i,
  output logic                        out_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [skgs_pkg::KvalW-1:0]  out_kval_o,
  output logic                        out_last_o,
  output logic                        out_sat_o
);

  localparam int unsigned KW = skgs_pkg::KvalW;
  localparam int unsigned HW = KW / 2;

  // Previous-row line.
  logic [KW-1:0] line_mem [MAX_COLS+1];
  logic [KW-1:0] line_rd_q;

  // Increment and coefficients.
  logic [HW-1:0] dmag_q;
  logic          dneg_q;
  logic [KW-1:0] dvd_q, dvd_d;
  logic [1:0]    rem_q, rem_d;
  logic [KW-1:0] a_q, bmag_q;
  logic          bneg_q;

  // Neighbour values and their magnitudes.
  logic [KW-1:0] left_q, diag_q, up_q;
  logic [KW-1:0] left_mag_q, diag_mag_q, up_mag_q;
  logic [KW-1:0] up_v, up_mag_v;

  // Shared multiplier and accumulator.
  logic [HW-1:0]        mul_a, mul_b;
  logic [KW-1:0]        mul_d, mul_q;
  logic [1:0]           pp_sh_d, pp_sh_q;
  logic                 pp_neg_d, pp_neg_q, pp_valid_q;
  logic [KW-1:0]        sel_v, sel_c;
  logic [skgs_pkg::AccW-1:0] acc_q, pp_ext, magr;
  logic [skgs_pkg::QW-1:0]   q_q;
  logic                      rneg_q;

  // Result formation.
  logic [KW-1:0] kval;
  logic          sat;

  // Line memory: one read when an item arrives, one write when it completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      line_mem[line_addr_i] <= kval;
    end
    if (cmd_i.load) begin
      line_rd_q <= line_mem[line_addr_i];
    end
  end

  // Take the increment apart into sign and magnitude.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dneg_q <= in_data_i[skgs_pkg::DinW-1];
      dmag_q <= in_data_i[skgs_pkg::DinW-1] ? (HW'(0) - in_data_i) : in_data_i;
    end
  end

  // Operand selection for one partial product: term, then which halves.
  always_comb begin
    sel_v    = left_mag_q;
    sel_c    = a_q;
    pp_neg_d = left_q[KW-1];
    unique case (cmd_i.mac_step[3:2])
      2'd0: begin
        sel_v    = left_mag_q;
        sel_c    = a_q;
        pp_neg_d = left_q[KW-1];
      end
      2'd1: begin
        sel_v    = up_mag_q;
        sel_c    = a_q;
        pp_neg_d = up_q[KW-1];
      end
      default: begin
        // The diagonal term enters with the opposite sign.
        sel_v    = diag_mag_q;
        sel_c    = bmag_q;
        pp_neg_d = ~(diag_q[KW-1] ^ bneg_q);
      end
    endcase
    pp_sh_d = {1'b0, cmd_i.mac_step[1]} + {1'b0, cmd_i.mac_step[0]};
    if (cmd_i.square) begin
      mul_a = dmag_q;
      mul_b = dmag_q;
    end else begin
      mul_a = cmd_i.mac_step[1] ? sel_v[KW-1:HW] : sel_v[HW-1:0];
      mul_b = cmd_i.mac_step[0] ? sel_c[KW-1:HW] : sel_c[HW-1:0];
    end
  end

  assign mul_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    mul_q    <= mul_d;
    pp_sh_q  <= pp_sh_d;
    pp_neg_q <= pp_neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_valid_q <= 1'b0;
    end else begin
      pp_valid_q <= cmd_i.mac_issue;
    end
  end

  // Divide by twelve: the quarter of d*d + 6 is divided by three, one byte a step,
  // with the quotient shifted in at the bottom of the same register.
  always_comb begin
    logic [KW-1:0] v;
    logic [1:0]    r;
    logic [2:0]    r3;
    v = dvd_q;
    r = rem_q;
    for (int k = 0; k < 8; k++) begin
      r3 = {r, v[KW-1]};
      v  = {v[KW-2:0], 1'b0};
      if (r3 >= 3'd3) begin
        r3   = r3 - 3'd3;
        v[0] = 1'b1;
      end
      r = r3[1:0];
    end
    dvd_d = v;
    rem_d = r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dvd_q <= {2'b00, mul_q[KW-1:2] + skgs_pkg::DivBias[KW-1:2]
                       + (KW-2)'(({1'b0, mul_q[1:0]}
                                  + {1'b0, skgs_pkg::DivBias[1:0]}) >> 2)};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // Upper neighbour: boundary value in the first row, the line otherwise.
  assign up_v     = cmd_i.row_first ? skgs_pkg::OneQ32 : line_rd_q;
  assign up_mag_v = up_v[KW-1] ? (KW'(0) - up_v) : up_v;

  // Coefficients 1 + d/2 + d*d/12 and |1 - d*d/12|, and operand magnitudes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.coef) begin
      a_q <= dneg_q ? (skgs_pkg::OneQ32 + dvd_q - (KW'(dmag_q) << 15))
                    : (skgs_pkg::OneQ32 + dvd_q + (KW'(dmag_q) << 15));
      bneg_q     <= (dvd_q > skgs_pkg::OneQ32);
      bmag_q     <= (dvd_q > skgs_pkg::OneQ32) ? (dvd_q - skgs_pkg::OneQ32)
                                               : (skgs_pkg::OneQ32 - dvd_q);
      up_q       <= up_v;
      up_mag_q   <= up_mag_v;
      left_mag_q <= left_q[KW-1] ? (KW'(0) - left_q) : left_q;
      diag_mag_q <= diag_q[KW-1] ? (KW'(0) - diag_q) : diag_q;
    end
  end

  // Place the registered partial product at its weight.
  always_comb begin
    unique case (pp_sh_q)
      2'd0:    pp_ext = skgs_pkg::AccW'(mul_q);
      2'd1:    pp_ext = skgs_pkg::AccW'(mul_q) << HW;
      default: pp_ext = skgs_pkg::AccW'(mul_q) << KW;
    endcase
  end

  // Accumulator and rounding. A negative sum becomes its magnitude plus one half
  // through a single add on the inverted word.
  assign magr = acc_q[skgs_pkg::AccW-1] ? (~acc_q + skgs_pkg::RoundHalfInc)
                                        : (acc_q + skgs_pkg::RoundHalf);

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef) begin
      acc_q <= '0;
    end else if (pp_valid_q) begin
      acc_q <= pp_neg_q ? (acc_q - pp_ext) : (acc_q + pp_ext);
    end
    if (cmd_i.round) begin
      rneg_q <= acc_q[skgs_pkg::AccW-1];
      q_q    <= magr[skgs_pkg::AccW-1:HW];
    end
  end

  // Saturate to the signed Q32.32 range and restore the sign.
  always_comb begin
    if (!rneg_q) begin
      sat  = |q_q[skgs_pkg::QW-1:KW-1];
      kval = sat ? skgs_pkg::KvalMax : q_q[KW-1:0];
    end else begin
      sat  = (|q_q[skgs_pkg::QW-1:KW]) || (q_q[KW-1] && (|q_q[KW-2:0]));
      kval = sat ? skgs_pkg::KvalMin : (KW'(0) - q_q[KW-1:0]);
    end
  end

  // Left and diagonal neighbours for the next cell of the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= skgs_pkg::OneQ32;
      diag_q <= skgs_pkg::OneQ32;
    end else if (cmd_i.finish) begin
      left_q <= cmd_i.end_row ? skgs_pkg::OneQ32 : kval;
      diag_q <= cmd_i.end_row ? skgs_pkg::OneQ32 : up_q;
    end
  end

  // Result register: holds one item while the next one is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_kval_o <= kval;
      out_last_o <= cmd_i.grid_last;
      out_sat_o  <= sat;
    end
  end

  assign out_stall_o = out_valid_o && !out_ready_i;

endmodule

FILE: src/signature_kernel_grid_solver_core.sv
// Top level of the signature kernel grid solver.
// Each item is one increment inner product d (signed Q16.16) of a grid taken in
// row-major order; each result is the kernel value at the next grid point (signed
// Q32.32, saturated), with tlast on the final cell of a grid and tuser set when the
// value was clipped. After an item is accepted, its result is formed in order by
// squaring, the divide by twelve (a load, then one byte a cycle), the coefficients,
// the twelve partial products through the single 32x32 multiplier and their
// accumulation, rounding, and saturation into the result register. The next item
// is accepted in the cycle after a result is registered, while that result waits
// for the sink, so no item is taken before the result of the previous one is
// registered. Grid sizes are written through the configuration port between grids;
// a size of zero counts as one, and columns beyond MAX_COLS are capped.
module signature_kernel_grid_solver_core #(
  parameter int unsigned MAX_COLS = skgs_pkg::MaxColsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [skgs_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [skgs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [skgs_pkg::DinW-1:0]      s_axis_tdata,  // [31:0] increment_product
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [skgs_pkg::KvalW-1:0]     m_axis_tdata,  // [63:0] kernel_value
  output logic                           m_axis_tlast,  // grid_last
  output logic                           m_axis_tuser   // [0] saturated
);

  localparam int unsigned AddrW = $clog2(MAX_COLS + 1);

  skgs_pkg::skgs_cmd_t cmd;
  logic [AddrW-1:0]    line_addr;
  logic                out_stall;

  skgs_ctrl #(
    .MAX_COLS (MAX_COLS),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_stall_i (out_stall),
    .cmd_o       (cmd),
    .line_addr_o (line_addr)
  );

  skgs_datapath #(
    .MAX_COLS (MAX_COLS),
    .AddrW    (AddrW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .line_addr_i (line_addr),
    .in_data_i   (s_axis_tdata),
    .out_stall_o (out_stall),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kval_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_sat_o   (m_axis_tuser)
  );

endmodule
